/* hdl/mpta_pkg.sv */
// mpta_pkg: shared types, constants and small helper functions for the
// min-plus tile accumulator. Depends on nothing; every other file but mpta_ram imports it.

package mpta_pkg;

   localparam int ROWS      = 8;
   localparam int COLS      = 8;
   localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_IW    = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int RSP_DEPTH = COLS + 2;
   localparam int RSP_PW    = $clog2(RSP_DEPTH);
   localparam int RSP_CW    = $clog2(RSP_DEPTH + 1);

   localparam logic [30:0] INF_RESET = 31'd10000000;

   typedef enum logic [1:0] {
      ACT_LOAD_ACC = 2'd0,
      ACT_LOAD_B   = 2'd1,
      ACT_UPDATE   = 2'd2,
      ACT_READ     = 2'd3
   } action_type;

   // one request as it travels down the row of cells
   typedef struct packed {
      logic               valid;
      action_type         action;
      logic               row_ok;
      logic [2:0]         row;
      logic [2:0]         col;
      logic signed [31:0] value;
   } token_type;

   function automatic logic [ROW_AW-1:0] row_addr(input logic [2:0] row);
      logic [ROW_AW+2:0] wide;
      wide = {{ROW_AW{1'b0}}, row};
      return wide[ROW_AW-1:0];
   endfunction

   function automatic logic row_in_range(input logic [2:0] row);
      logic [6:0] r;
      r = 7'(row);
      return r < 7'(ROWS);
   endfunction

   function automatic logic col_match(input logic [2:0] col,
                                      input logic [COL_IW-1:0] idx);
      logic [4:0] a;
      logic [4:0] b;
      a = 5'(col);
      b = 5'(idx);
      return a == b;
   endfunction

   // signed compare against a non-negative threshold
   function automatic logic is_inf(input logic signed [31:0] v,
                                   input logic [30:0] inf);
      return !v[31] && (v[30:0] >= inf);
   endfunction

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = 33'(a) + 33'(b);
      if (s[32] != s[31]) begin
         return s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end
      return s[31:0];
   endfunction

endpackage

/* hdl/mpta_ram.sv */
// mpta_ram: generic simple dual-port ram, one write and one registered read.
// Depends on nothing.

module mpta_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/mpta_cell.sv */
// mpta_cell: one column of the tile: its accumulators in a ram, its B
// operand, and one stage of the request chain. Depends on mpta_pkg, mpta_ram.

module mpta_cell
   import mpta_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [COL_IW-1:0]  col_index,
   input  logic [30:0]        inf_value,
   input  token_type          tok_in,
   input  logic signed [31:0] data_in,
   output token_type          tok_out,
   output logic signed [31:0] data_out
);

   token_type          tok_ff;
   logic signed [31:0] data_ff;
   logic signed [31:0] b_ff;
   logic signed [31:0] b_in;
   logic               byp_ff;
   logic               byp_in;
   logic signed [31:0] byp_data_ff;
   logic signed [31:0] byp_data_in;
   logic [31:0]        rd_data;
   logic signed [31:0] acc_now;
   logic signed [31:0] sum;
   logic               col_hit;
   logic               we;
   logic [ROW_AW-1:0]  waddr;
   logic signed [31:0] wdata;

   // read is issued as the request arrives, so data lines up with tok_ff
   mpta_ram #(
      .WIDTH(32),
      .DEPTH(ROWS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_en   (tok_in.valid),
      .rd_addr (row_addr(tok_in.row)),
      .rd_data (rd_data)
   );

   assign col_hit = col_match(tok_ff.col, col_index);
   // the request just behind may read the row written this cycle
   assign acc_now = byp_ff ? byp_data_ff : $signed(rd_data);
   assign sum     = sat_add(tok_ff.value, b_ff);

   always_comb begin
      we    = 1'b0;
      waddr = row_addr(tok_ff.row);
      wdata = sum;
      if (tok_ff.valid && tok_ff.row_ok) begin
         case (tok_ff.action)
            ACT_LOAD_ACC: begin
               if (col_hit) begin
                  we    = 1'b1;
                  wdata = tok_ff.value;
               end
            end
            ACT_UPDATE: begin
               if (!is_inf(tok_ff.value, inf_value) && !is_inf(b_ff, inf_value)
                   && (sum < acc_now)) begin
                  we = 1'b1;
               end
            end
            default: begin
               we = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      b_in = b_ff;
      if (tok_ff.valid && (tok_ff.action == ACT_LOAD_B) && col_hit) begin
         b_in = tok_ff.value;
      end
   end

   assign byp_in      = we && tok_in.valid && (waddr == row_addr(tok_in.row));
   assign byp_data_in = wdata;

   assign data_out = (tok_ff.valid && (tok_ff.action == ACT_READ) && tok_ff.row_ok
                      && col_hit) ? acc_now : data_ff;
   assign tok_out  = tok_ff;

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      b_ff        <= b_in;
      byp_data_ff <= byp_data_in;
      if (reset) begin
         tok_ff <= '0;
         byp_ff <= 1'b0;
      end else begin
         tok_ff <= tok_in;
         byp_ff <= byp_in;
      end
   end

endmodule

/* hdl/mpta_rsp_fifo.sv */
// mpta_rsp_fifo: small response queue at the end of the cell chain.
// Depends on mpta_pkg.

module mpta_rsp_fifo
   import mpta_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic signed [31:0] push_data,
   input  logic               pop,
   output logic               valid,
   output logic signed [31:0] data
);

   logic signed [31:0] mem_ff [RSP_DEPTH];
   logic [RSP_PW-1:0]  wr_ptr_ff;
   logic [RSP_PW-1:0]  wr_ptr_in;
   logic [RSP_PW-1:0]  rd_ptr_ff;
   logic [RSP_PW-1:0]  rd_ptr_in;
   logic [RSP_CW-1:0]  count_ff;
   logic [RSP_CW-1:0]  count_in;

   function automatic logic [RSP_PW-1:0] next_ptr(input logic [RSP_PW-1:0] p);
      return (p == RSP_PW'(RSP_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
   assign rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign valid = (count_ff != '0);
   assign data  = mem_ff[rd_ptr_ff];

endmodule

/* hdl/min_plus_tile_accumulator_unit.sv */
// min_plus_tile_accumulator_unit: top level, a chain of COLS column cells
// plus a response queue. Depends on mpta_pkg, mpta_cell, mpta_rsp_fifo.
//
// Usage:
//  - req_* carries one request: load accumulator, load B operand, row update
//    (acc = min(acc, a + B) per column, operands at or above inf skipped) or
//    read accumulator. Only a read gives a response, on rsp_*.
//  - csr_* writes the infinity threshold; it is taken in any cycle outside
//    reset and should only be changed while the block is idle.
//  - A request enters the first cell at acceptance and moves one cell per
//    cycle; cell c owns column c. One request is accepted every cycle while req_ready is high.
//  - A read is shown on rsp_valid after it has passed the registers of all COLS
//    cells in order and been written into the response queue.
//  - The response queue holds COLS+2 entries and req_ready counts reads in
//    flight against it: when the receiver stalls, req_ready drops once that
//    many reads are outstanding, and nothing is lost.
//  - Reset clears the request chain, queue and threshold (to 10000000).
//    Accumulators and B operands are not cleared and hold garbage until
//    written; there is no clearing pass, requests are taken straight away.

module min_plus_tile_accumulator_unit
   import mpta_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [2:0]         req_row,
   input  logic [2:0]         req_col,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_read_value,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [30:0]        csr_inf_value
);

   logic [30:0]        inf_ff;
   logic [30:0]        inf_in;
   logic [RSP_CW-1:0]  used_ff;
   logic [RSP_CW-1:0]  used_in;
   logic               accept;
   logic               read_acc;
   logic               pop;
   logic               push;
   token_type          tok_chain [COLS+1];
   logic signed [31:0] data_chain [COLS+1];

   assign csr_ready = !reset;
   assign inf_in    = (csr_valid && csr_ready) ? csr_inf_value : inf_ff;

   assign req_ready = !reset && (used_ff < RSP_CW'(RSP_DEPTH));
   assign accept    = req_valid && req_ready;
   assign read_acc  = accept && (action_type'(req_action) == ACT_READ);
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      case ({read_acc, pop})
         2'b10:   used_in = used_ff + 1'b1;
         2'b01:   used_in = used_ff - 1'b1;
         default: used_in = used_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inf_ff  <= INF_RESET;
         used_ff <= '0;
      end else begin
         inf_ff  <= inf_in;
         used_ff <= used_in;
      end
   end

   always_comb begin
      tok_chain[0].valid  = accept;
      tok_chain[0].action = action_type'(req_action);
      tok_chain[0].row_ok = row_in_range(req_row);
      tok_chain[0].row    = req_row;
      tok_chain[0].col    = req_col;
      tok_chain[0].value  = req_value;
   end

   // out-of-range reads never hit a cell and come out as zero
   assign data_chain[0] = '0;

   for (genvar g = 0; g < COLS; g++) begin : g_cell
      mpta_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .col_index (COL_IW'(g)),
         .inf_value (inf_ff),
         .tok_in    (tok_chain[g]),
         .data_in   (data_chain[g]),
         .tok_out   (tok_chain[g+1]),
         .data_out  (data_chain[g+1])
      );
   end

   assign push = tok_chain[COLS].valid && (tok_chain[COLS].action == ACT_READ);

   mpta_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (data_chain[COLS]),
      .pop       (pop),
      .valid     (rsp_valid),
      .data      (rsp_read_value)
   );

endmodule

/* hdl/mpta_checker.sv */
// mpta_checker: port-level checks on the min-plus tile accumulator, bound to
// the top level below. Depends on mpta_pkg and min_plus_tile_accumulator_unit.

module mpta_checker
   import mpta_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_action,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_read_value
);

   logic [RSP_CW:0] outst_ff;
   logic [RSP_CW:0] outst_in;
   logic            rd_req;
   logic            rsp_pop;

   assign rd_req  = req_valid && req_ready && (req_action == ACT_READ);
   assign rsp_pop = rsp_valid && rsp_ready;

   always_comb begin
      case ({rd_req, rsp_pop})
         2'b10:   outst_in = outst_ff + 1'b1;
         2'b01:   outst_in = outst_ff - 1'b1;
         default: outst_in = outst_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value))
      else $error("response changed while stalled");

   // a fresh response must match a read request accepted at the time set by the length of the cell chain
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |->
         $past(req_valid && req_ready && (req_action == ACT_READ), COLS + 1))
      else $error("response without a read request at the expected time");

   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (outst_ff != '0))
      else $error("response with no read request outstanding");

   a_outst_bound: assert property (@(posedge clock) disable iff (reset)
      outst_ff <= (RSP_CW + 1)'(RSP_DEPTH))
      else $error("more reads outstanding than the response queue holds");

endmodule

bind min_plus_tile_accumulator_unit mpta_checker u_mpta_checker (.*);
